// File: rtl/first_order_advection_stencil_core_assert.svh
// Assertion macros for the advection stencil core.
`ifndef FIRST_ORDER_ADVECTION_STENCIL_CORE_ASSERT_SVH
`define FIRST_ORDER_ADVECTION_STENCIL_CORE_ASSERT_SVH
`ifndef SYNTH
// clocked check, off while reset is asserted
`define FOAS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked check, also active during reset
`define FOAS_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FOAS_ASSERT(lbl, clk, rst_n, prop, msg)
`define FOAS_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

// File: rtl/foas_pkg.sv
// Shared constants, codes and helpers for the advection stencil core.
package foas_pkg;

  localparam int unsigned MAX_CELLS_DEF = 16;
  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned CFG_AW        = 5;

  localparam logic [2:0] MODE_LOAD_CELL = 3'd0;
  localparam logic [2:0] MODE_LOAD_X    = 3'd1;
  localparam logic [2:0] MODE_LOAD_Y    = 3'd2;
  localparam logic [2:0] MODE_LOAD_Z    = 3'd3;
  localparam logic [2:0] MODE_COMPUTE   = 3'd4;
  localparam logic [2:0] MODE_READ      = 3'd5;

  localparam logic [1:0] STATUS_OK           = 2'd0;
  localparam logic [1:0] STATUS_RANGE        = 2'd1;
  localparam logic [1:0] STATUS_NOT_COMPUTED = 2'd2;

  localparam logic [2:0] REG_TIME_STEP = 3'd0;
  localparam logic [2:0] REG_SIZE_X    = 3'd1;
  localparam logic [2:0] REG_SIZE_Y    = 3'd2;
  localparam logic [2:0] REG_SIZE_Z    = 3'd3;
  localparam logic [2:0] REG_CELLS_X   = 3'd4;
  localparam logic [2:0] REG_CELLS_Y   = 3'd5;
  localparam logic [2:0] REG_CELLS_Z   = 3'd6;

  // slab order inside one outflux record
  localparam logic [2:0] F_TOP    = 3'd0;
  localparam logic [2:0] F_BOTTOM = 3'd1;
  localparam logic [2:0] F_RIGHT  = 3'd2;
  localparam logic [2:0] F_LEFT   = 3'd3;
  localparam logic [2:0] F_FRONT  = 3'd4;
  localparam logic [2:0] F_BACK   = 3'd5;

  function automatic logic signed [31:0] sat_to32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] pos0(input logic signed [31:0] v);
    return v[31] ? 32'sd0 : v;
  endfunction

  // slab of a neighbor that flows into the center; neighbor 0 is the cell itself
  function automatic logic [2:0] nb_field(input logic [2:0] j);
    case (j)
      3'd1:    return F_BOTTOM;
      3'd2:    return F_TOP;
      3'd3:    return F_LEFT;
      3'd4:    return F_RIGHT;
      3'd5:    return F_BACK;
      3'd6:    return F_FRONT;
      default: return F_TOP;
    endcase
  endfunction

endpackage

// File: rtl/first_order_advection_stencil_core.sv
// Top level of the donor-cell advection stencil core.
// Load items: accepted in idle, result registered into the output after the finish state.
// Read items: seven sequential reads of the single cell and outflux memory ports.
// Compute items: a walk over (cells_x+2)*(cells_y+2)*(cells_z+2) cells; the 15 products of
// each cell go one after another through the one shared multiplier.
// Reset (async, active low) clears control, fluxes-not-computed, output valid; no memory clear.
`include "first_order_advection_stencil_core_assert.svh"
module first_order_advection_stencil_core #(
  parameter int unsigned MAX_CELLS_PER_AXIS = foas_pkg::MAX_CELLS_DEF,
  parameter int unsigned FRAC_BITS          = foas_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input transactions
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [2:0]                  mode_i,
  input  logic [4:0]                  pos_x_i,
  input  logic [4:0]                  pos_y_i,
  input  logic [4:0]                  pos_z_i,
  input  logic signed [31:0]          value_i,
  // result transactions
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [31:0]          advected_value_o,
  output logic                        outflux_error_o,
  output logic [4:0]                  error_x_o,
  output logic [4:0]                  error_y_o,
  output logic [4:0]                  error_z_o,
  output logic [1:0]                  status_o,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [foas_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import foas_pkg::*;

  // grid geometry: one ghost layer each side plus one spare for neighbor reads
  localparam int unsigned SIDE  = MAX_CELLS_PER_AXIS + 3;
  localparam int unsigned DEPTH = SIDE * SIDE * SIDE;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam logic [AW-1:0] SIDE_A  = AW'(SIDE);
  localparam logic [AW-1:0] PLANE_A = AW'(SIDE * SIDE);

  // sequencer states
  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_FIN   = 5'd1;
  localparam logic [4:0] S_VOL_A = 5'd2;
  localparam logic [4:0] S_VOL_B = 5'd3;
  localparam logic [4:0] S_VOL_C = 5'd4;
  localparam logic [4:0] S_VOL_D = 5'd5;
  localparam logic [4:0] S_RD0   = 5'd6;
  localparam logic [4:0] S_RD1   = 5'd7;
  localparam logic [4:0] S_RD2   = 5'd8;
  localparam logic [4:0] S_MI    = 5'd9;
  localparam logic [4:0] S_MT    = 5'd10;
  localparam logic [4:0] S_WR    = 5'd11;
  localparam logic [4:0] S_AR    = 5'd12;
  localparam logic [4:0] S_AW    = 5'd13;
  localparam logic [4:0] S_SUM   = 5'd14;
  localparam logic [4:0] S_AO    = 5'd15;
  localparam logic [4:0] S_AT    = 5'd16;

  function automatic logic [4:0] clamp_cells(input logic [4:0] v);
    logic [4:0] c;
    c = v;
    if (c == 5'd0) c = 5'd1;
    if (int'(c) > MAX_CELLS_PER_AXIS) c = 5'(MAX_CELLS_PER_AXIS);
    return c;
  endfunction

  function automatic logic [AW-1:0] at_addr(input logic [5:0] x, input logic [5:0] y,
                                            input logic [5:0] z);
    return (AW'(z) * SIDE_A + AW'(y)) * SIDE_A + AW'(x);
  endfunction

  // ---------------------------------------------------------------- config regs
  logic [30:0] ts_q, dx_q, dy_q, dz_q;
  logic [4:0]  nx_q, ny_q, nz_q;
  logic        cfg_we;
  logic [2:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ts_q <= 31'd655;
      dx_q <= 31'd65536;
      dy_q <= 31'd65536;
      dz_q <= 31'd65536;
      nx_q <= clamp_cells(5'd16);
      ny_q <= clamp_cells(5'd16);
      nz_q <= clamp_cells(5'd16);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_TIME_STEP: ts_q <= pwdata[30:0];
        REG_SIZE_X:    dx_q <= pwdata[30:0];
        REG_SIZE_Y:    dy_q <= pwdata[30:0];
        REG_SIZE_Z:    dz_q <= pwdata[30:0];
        REG_CELLS_X:   nx_q <= clamp_cells(pwdata[4:0]);
        REG_CELLS_Y:   ny_q <= clamp_cells(pwdata[4:0]);
        REG_CELLS_Z:   nz_q <= clamp_cells(pwdata[4:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_TIME_STEP: prdata = {1'b0, ts_q};
      REG_SIZE_X:    prdata = {1'b0, dx_q};
      REG_SIZE_Y:    prdata = {1'b0, dy_q};
      REG_SIZE_Z:    prdata = {1'b0, dz_q};
      REG_CELLS_X:   prdata = {27'd0, nx_q};
      REG_CELLS_Y:   prdata = {27'd0, ny_q};
      REG_CELLS_Z:   prdata = {27'd0, nz_q};
      default:       prdata = 32'd0;
    endcase
  end

  // any register in the list makes stored fluxes stale
  logic cfg_stale;
  assign cfg_stale = cfg_we && (cfg_idx <= REG_CELLS_Z);

  // ---------------------------------------------------------------- state
  logic [4:0]         state_q, state_d;
  logic               flux_valid_q, flux_valid_d;
  logic               out_valid_q, out_valid_d;
  logic               out_load;

  logic [5:0]         cx_q, cx_d, cy_q, cy_d, cz_q, cz_d;
  logic [3:0]         m_q, m_d;
  logic [2:0]         j_q, j_d;
  logic signed [31:0] fv_q [6];   // face velocities: y hi, y lo, x hi, x lo, z hi, z lo
  logic signed [31:0] fv_d [6];
  logic signed [31:0] tv_q [6];   // dt-scaled slab widths, in slab order
  logic signed [31:0] tv_d [6];
  logic signed [31:0] pr_q [3];   // face areas: xz, xy, yz
  logic signed [31:0] pr_d [3];
  logic signed [31:0] f_q [6];
  logic signed [31:0] f_d [6];
  logic signed [34:0] total_q, total_d;
  logic signed [34:0] own_q, own_d;
  logic signed [35:0] acc_q, acc_d;
  logic signed [31:0] vol_q, vol_d;
  logic               err_q, err_d;
  logic [4:0]         ex_q, ex_d, ey_q, ey_d, ez_q, ez_d;

  logic signed [31:0] res_val_q, res_val_d;
  logic               res_err_q, res_err_d;
  logic [4:0]         res_ex_q, res_ex_d, res_ey_q, res_ey_d, res_ez_q, res_ez_d;
  logic [1:0]         res_st_q, res_st_d;

  logic signed [31:0] out_val_q;
  logic               out_err_q;
  logic [4:0]         out_ex_q, out_ey_q, out_ez_q;
  logic [1:0]         out_st_q;

  // ---------------------------------------------------------------- input decode
  logic          in_accept;
  logic          load_ok, read_ok;
  logic [AW-1:0] load_addr;
  logic          cell_we, xf_we, yf_we, zf_we;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  assign load_ok = ({1'b0, pos_x_i} <= 6'({1'b0, nx_q}) + 6'd2) &&
                   ({1'b0, pos_y_i} <= 6'({1'b0, ny_q}) + 6'd2) &&
                   ({1'b0, pos_z_i} <= 6'({1'b0, nz_q}) + 6'd2);
  assign read_ok = (pos_x_i != 5'd0) && (pos_x_i <= nx_q) &&
                   (pos_y_i != 5'd0) && (pos_y_i <= ny_q) &&
                   (pos_z_i != 5'd0) && (pos_z_i <= nz_q);
  assign load_addr = at_addr({1'b0, pos_x_i}, {1'b0, pos_y_i}, {1'b0, pos_z_i});

  assign cell_we = in_accept && load_ok && (mode_i == MODE_LOAD_CELL);
  assign xf_we   = in_accept && load_ok && (mode_i == MODE_LOAD_X);
  assign yf_we   = in_accept && load_ok && (mode_i == MODE_LOAD_Y);
  assign zf_we   = in_accept && load_ok && (mode_i == MODE_LOAD_Z);

  // ---------------------------------------------------------------- addressing
  logic [AW-1:0] cur_addr, xf_raddr, yf_raddr, zf_raddr, rd_addr;
  logic [5:0]    lim_x, lim_y, lim_z;

  assign cur_addr = at_addr(cx_q, cy_q, cz_q);
  assign lim_x    = 6'({1'b0, nx_q}) + 6'd1;
  assign lim_y    = 6'({1'b0, ny_q}) + 6'd1;
  assign lim_z    = 6'({1'b0, nz_q}) + 6'd1;

  // first read the own faces, then the high-side faces
  assign xf_raddr = (state_q == S_RD1) ? cur_addr + AW'(1) : cur_addr;
  assign yf_raddr = (state_q == S_RD1) ? cur_addr + SIDE_A : cur_addr;
  assign zf_raddr = (state_q == S_RD1) ? cur_addr + PLANE_A : cur_addr;

  always_comb begin
    case (j_q)
      3'd1:    rd_addr = cur_addr + SIDE_A;
      3'd2:    rd_addr = cur_addr - SIDE_A;
      3'd3:    rd_addr = cur_addr + AW'(1);
      3'd4:    rd_addr = cur_addr - AW'(1);
      3'd5:    rd_addr = cur_addr + PLANE_A;
      3'd6:    rd_addr = cur_addr - PLANE_A;
      default: rd_addr = cur_addr;
    endcase
  end

  // ---------------------------------------------------------------- memories
  logic signed [31:0] cell_mem [DEPTH];
  logic signed [31:0] xf_mem [DEPTH];
  logic signed [31:0] yf_mem [DEPTH];
  logic signed [31:0] zf_mem [DEPTH];
  logic [191:0]       of_mem [DEPTH];

  logic signed [31:0] cell_rd_q, xf_rd_q, yf_rd_q, zf_rd_q;
  logic [191:0]       of_rd_q;
  logic               of_we;
  logic signed [31:0] fr [6];

  assign of_we = (state_q == S_WR);

  always_ff @(posedge clk_i) begin
    if (cell_we) cell_mem[load_addr] <= value_i;
    cell_rd_q <= cell_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (xf_we) xf_mem[load_addr] <= value_i;
    xf_rd_q <= xf_mem[xf_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (yf_we) yf_mem[load_addr] <= value_i;
    yf_rd_q <= yf_mem[yf_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (zf_we) zf_mem[load_addr] <= value_i;
    zf_rd_q <= zf_mem[zf_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (of_we) of_mem[cur_addr] <= {f_q[5], f_q[4], f_q[3], f_q[2], f_q[1], f_q[0]};
    of_rd_q <= of_mem[rd_addr];
  end

  always_comb begin
    for (int k = 0; k < 6; k++) fr[k] = of_rd_q[32*k +: 32];
  end

  // ---------------------------------------------------------------- shared multiplier
  logic signed [31:0] mul_a, mul_b, mul_q;

  foas_qmul #(
    .FRAC_BITS(FRAC_BITS)
  ) u_qmul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .q_o   (mul_q)
  );

  // remaining slab edges; the difference can fall below -2^31, so it is formed signed at 64 bits
  logic signed [31:0] xr, yr, zr, dt_s;
  logic [3:0]         mi;
  logic               gt_vol;

  assign dt_s = {1'b0, ts_q};
  assign xr = sat_to32(64'(signed'({1'b0, dx_q})) - 64'(tv_q[2]) - 64'(tv_q[3]));
  assign yr = sat_to32(64'(signed'({1'b0, dy_q})) - 64'(tv_q[0]) - 64'(tv_q[1]));
  assign zr = sat_to32(64'(signed'({1'b0, dz_q})) - 64'(tv_q[4]) - 64'(tv_q[5]));
  assign mi = m_q - 4'd9;
  assign gt_vol = total_q > 35'(vol_q);

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_d      = state_q;
    flux_valid_d = flux_valid_q;
    cx_d = cx_q;  cy_d = cy_q;  cz_d = cz_q;
    m_d  = m_q;   j_d  = j_q;
    fv_d = fv_q;  tv_d = tv_q;  pr_d = pr_q;  f_d = f_q;
    total_d = total_q;  own_d = own_q;  acc_d = acc_q;  vol_d = vol_q;
    err_d = err_q;  ex_d = ex_q;  ey_d = ey_q;  ez_d = ez_q;
    res_val_d = res_val_q;  res_err_d = res_err_q;
    res_ex_d = res_ex_q;  res_ey_d = res_ey_q;  res_ez_d = res_ez_q;
    res_st_d = res_st_q;
    mul_a    = 32'sd0;
    mul_b    = 32'sd0;
    out_load = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          res_val_d = 32'sd0;
          res_err_d = 1'b0;
          res_ex_d  = 5'd0;
          res_ey_d  = 5'd0;
          res_ez_d  = 5'd0;
          res_st_d  = STATUS_OK;
          unique case (mode_i) inside
            MODE_LOAD_CELL, MODE_LOAD_X, MODE_LOAD_Y, MODE_LOAD_Z: begin
              if (!load_ok) res_st_d = STATUS_RANGE;
              else if (mode_i != MODE_LOAD_CELL) flux_valid_d = 1'b0;
              state_d = S_FIN;
            end
            MODE_COMPUTE: begin
              cx_d  = 6'd0;
              cy_d  = 6'd0;
              cz_d  = 6'd0;
              err_d = 1'b0;
              ex_d  = 5'd0;
              ey_d  = 5'd0;
              ez_d  = 5'd0;
              state_d = S_VOL_A;
            end
            MODE_READ: begin
              if (!read_ok) begin
                res_st_d = STATUS_RANGE;
                state_d  = S_FIN;
              end else if (!flux_valid_q) begin
                res_st_d = STATUS_NOT_COMPUTED;
                state_d  = S_FIN;
              end else begin
                cx_d = {1'b0, pos_x_i};
                cy_d = {1'b0, pos_y_i};
                cz_d = {1'b0, pos_z_i};
                j_d  = 3'd0;
                state_d = S_AR;
              end
            end
            default: ;
          endcase
        end
      end
      S_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      // cell volume dx*dy*dz
      S_VOL_A: begin
        mul_a = {1'b0, dx_q};
        mul_b = {1'b0, dy_q};
        state_d = S_VOL_B;
      end
      S_VOL_B: begin
        vol_d   = mul_q;
        state_d = S_VOL_C;
      end
      S_VOL_C: begin
        mul_a = vol_q;
        mul_b = {1'b0, dz_q};
        state_d = S_VOL_D;
      end
      S_VOL_D: begin
        vol_d   = mul_q;
        state_d = S_RD0;
      end
      // per-cell walk
      S_RD0: begin
        total_d = 35'sd0;
        state_d = S_RD1;
      end
      S_RD1: begin
        fv_d[1] = yf_rd_q;
        fv_d[3] = xf_rd_q;
        fv_d[5] = zf_rd_q;
        state_d = S_RD2;
      end
      S_RD2: begin
        fv_d[0] = yf_rd_q;
        fv_d[2] = xf_rd_q;
        fv_d[4] = zf_rd_q;
        m_d     = 4'd0;
        state_d = S_MI;
      end
      S_MI: begin
        if (m_q < 4'd6) begin
          mul_a = fv_q[m_q[2:0]];
          mul_b = dt_s;
        end else if (m_q == 4'd6) begin
          mul_a = xr;
          mul_b = zr;
        end else if (m_q == 4'd7) begin
          mul_a = xr;
          mul_b = yr;
        end else if (m_q == 4'd8) begin
          mul_a = yr;
          mul_b = zr;
        end else begin
          mul_a = tv_q[mi[2:0]];
          // top/bottom use xz, right/left yz, front/back xy
          if (mi < 4'd2)      mul_b = pr_q[0];
          else if (mi < 4'd4) mul_b = pr_q[2];
          else                mul_b = pr_q[1];
        end
        state_d = S_MT;
      end
      S_MT: begin
        if (m_q < 4'd6) begin
          // high face flows out when positive, low face when negative
          tv_d[m_q[2:0]] = m_q[0] ? pos0(sat_to32(-64'(mul_q))) : pos0(mul_q);
        end else if (m_q < 4'd9) begin
          pr_d[2'(m_q - 4'd6)] = mul_q;
        end else begin
          f_d[mi[2:0]] = mul_q;
          total_d      = total_q + 35'(mul_q);
        end
        if (m_q == 4'd14) begin
          state_d = S_WR;
        end else begin
          m_d     = m_q + 4'd1;
          state_d = S_MI;
        end
      end
      S_WR: begin
        if (!err_q && gt_vol) begin
          err_d = 1'b1;
          ex_d  = cx_q[4:0];
          ey_d  = cy_q[4:0];
          ez_d  = cz_q[4:0];
        end
        state_d = S_RD0;
        if (cx_q == lim_x) begin
          cx_d = 6'd0;
          if (cy_q == lim_y) begin
            cy_d = 6'd0;
            if (cz_q == lim_z) begin
              flux_valid_d = 1'b1;
              res_err_d    = err_d;
              res_ex_d     = ex_d;
              res_ey_d     = ey_d;
              res_ez_d     = ez_d;
              state_d      = S_FIN;
            end else begin
              cz_d = cz_q + 6'd1;
            end
          end else begin
            cy_d = cy_q + 6'd1;
          end
        end else begin
          cx_d = cx_q + 6'd1;
        end
      end
      // read: own record first, then six neighbors
      S_AR: state_d = S_AW;
      S_AW: begin
        if (j_q == 3'd0) begin
          own_d   = 35'sd0;
          m_d     = 4'd0;
          state_d = S_SUM;
        end else begin
          mul_a   = cell_rd_q;
          mul_b   = fr[nb_field(j_q)];
          state_d = S_AT;
        end
      end
      S_SUM: begin
        own_d = own_q + 35'(fr[m_q[2:0]]);
        if (m_q == 4'd5) state_d = S_AO;
        else             m_d = m_q + 4'd1;
      end
      S_AO: begin
        mul_a   = sat_to32(64'(own_q));
        mul_b   = cell_rd_q;
        state_d = S_AT;
      end
      S_AT: begin
        if (j_q == 3'd0) acc_d = -36'(mul_q);
        else             acc_d = acc_q + 36'(mul_q);
        if (j_q == 3'd6) begin
          res_val_d = sat_to32(64'(acc_d));
          state_d   = S_FIN;
        end else begin
          j_d     = j_q + 3'd1;
          state_d = S_AR;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (cfg_stale) flux_valid_d = 1'b0;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load)         out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      flux_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      flux_valid_q <= flux_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cx_q <= cx_d;  cy_q <= cy_d;  cz_q <= cz_d;
    m_q  <= m_d;   j_q  <= j_d;
    fv_q <= fv_d;  tv_q <= tv_d;  pr_q <= pr_d;  f_q <= f_d;
    total_q <= total_d;  own_q <= own_d;  acc_q <= acc_d;  vol_q <= vol_d;
    err_q <= err_d;  ex_q <= ex_d;  ey_q <= ey_d;  ez_q <= ez_d;
    res_val_q <= res_val_d;  res_err_q <= res_err_d;
    res_ex_q <= res_ex_d;  res_ey_q <= res_ey_d;  res_ez_q <= res_ez_d;
    res_st_q <= res_st_d;
    if (out_load) begin
      out_val_q <= res_val_q;
      out_err_q <= res_err_q;
      out_ex_q  <= res_ex_q;
      out_ey_q  <= res_ey_q;
      out_ez_q  <= res_ez_q;
      out_st_q  <= res_st_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign advected_value_o = out_val_q;
  assign outflux_error_o  = out_err_q;
  assign error_x_o        = out_ex_q;
  assign error_y_o        = out_ey_q;
  assign error_z_o        = out_ez_q;
  assign status_o         = out_st_q;

  // ---------------------------------------------------------------- checks
  `FOAS_ASSERT(a_flux_valid_src, clk_i, rst_ni, $rose(flux_valid_q) |-> ($past(state_q) == S_WR), "fluxes marked valid outside the end of a compute walk")
  `FOAS_ASSERT(a_out_slot_free, clk_i, rst_ni, out_load |-> (!out_valid_q || !out_stall_i), "result loaded over a pending transaction")
  `FOAS_ASSERT(a_mul_index, clk_i, rst_ni, (state_q == S_MT) |-> (m_q <= 4'd14), "product index past the last flux")
  `FOAS_ASSERT(a_nb_index, clk_i, rst_ni, (state_q == S_AT) |-> (j_q <= 3'd6), "neighbor index past the last neighbor")
  `FOAS_ASSERT_NR(a_status_code, clk_i, out_valid_o |-> (status_o <= STATUS_NOT_COMPUTED), "undefined status code on output")

endmodule

// File: rtl/foas_qmul.sv
// Shared fixed point multiplier: registered product, floor shift, saturation.
module foas_qmul #(
  parameter int unsigned FRAC_BITS = foas_pkg::FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  output logic signed [31:0] q_o
);
  import foas_pkg::*;

  logic signed [63:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= 64'(a_i) * 64'(b_i);
  end

  // arithmetic shift rounds toward minus infinity
  assign q_o = sat_to32(p_q >>> FRAC_BITS);

endmodule
